/* src/drsm_pkg.sv */
// ----------------------------------------------------------------------------
// drsm_pkg
// Shared types and constants of the disjoint range set merge unit.
// ----------------------------------------------------------------------------
`default_nettype none
package drsm_pkg;
	localparam int MAX_RANGES = 32;
	localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CNT_W = $clog2(MAX_RANGES + 1);
	localparam int VAL_W = 32;

	typedef enum logic [2:0] {
		ST_COVERED    = 3'd0,
		ST_JOINED     = 3'd1,
		ST_UPPER_DOWN = 3'd2,
		ST_LOWER_UP   = 3'd3,
		ST_NEW        = 3'd4,
		ST_FULL       = 3'd5,
		ST_LISTED     = 3'd6,
		ST_EMPTY      = 3'd7
	} status_t;

	typedef enum logic [3:0] {
		FSM_IDLE,
		FSM_SRCH,
		FSM_SRCH_CHK,
		FSM_DECIDE,
		FSM_SHDN,
		FSM_SHDN_W,
		FSM_SHUP,
		FSM_SHUP_W,
		FSM_LIST,
		FSM_LIST_W,
		FSM_EMIT
	} fsm_t;

	typedef struct packed {
		logic        kind;
		logic signed [VAL_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic signed [VAL_W-1:0] range_low;
		logic signed [VAL_W-1:0] range_high;
		logic        last;
	} out_item_t;
endpackage
`default_nettype wire

/* src/drsm_if.sv */
// ----------------------------------------------------------------------------
// drsm_if
// Valid/ready channel that carries one item.
// ----------------------------------------------------------------------------
`default_nettype none
interface drsm_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/drsm_ram.sv */
// ----------------------------------------------------------------------------
// drsm_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module drsm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

/* src/disjoint_range_set_merge_unit.sv */
// ----------------------------------------------------------------------------
// disjoint_range_set_merge_unit
// Sorted table of disjoint ranges in one RAM; adds a value with merging, or
// lists all ranges in ascending order.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  in_ch    in   kind, value
//  out_ch   out  status, range_low, range_high, last
//
// One item at a time. An add scans the table entry by entry in the search and
// check states, then for a new range or a join shifts the entries above the
// insert or join point with a read and a write state per entry. A list reads
// each range in the list, wait and emit states. Reset clears the state, count
// and output valid flag; the RAM needs no clearing. A stalled output holds the
// list sequencer, and no new item is taken until the last result has left.
`default_nettype none
module disjoint_range_set_merge_unit (
	input wire logic clk,
	input wire logic arst_n,
	drsm_if.sink     in_ch,
	drsm_if.source   out_ch
);
	import drsm_pkg::*;

	localparam int EW = 2 * VAL_W;

	fsm_t state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] up_q;
	logic signed [VAL_W-1:0] v_q;
	logic signed [VAL_W-1:0] lo_s_q, lo_e_q;
	logic has_down_q;
	out_item_t out_q;
	logic out_v_q;

	logic ram_we;
	logic [IDX_W-1:0] ram_addr;
	logic [EW-1:0] ram_wdata, ram_rdata;
	logic signed [VAL_W-1:0] rd_s, rd_e;

	drsm_ram #(.WIDTH(EW), .DEPTH(1 << IDX_W)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	assign rd_s = ram_rdata[EW-1:VAL_W];
	assign rd_e = ram_rdata[VAL_W-1:0];

	logic signed [VAL_W:0] vp1, vm1;
	assign vp1 = {v_q[VAL_W-1], v_q} + 33'sd1;
	assign vm1 = {v_q[VAL_W-1], v_q} - 33'sd1;

	logic has_up, cov, up_adj, dn_adj;
	assign has_up = up_q < count_q;
	assign cov = (has_up && rd_s <= v_q) || (has_down_q && lo_e_q >= v_q);
	assign up_adj = has_up && ({rd_s[VAL_W-1], rd_s} == vp1);
	assign dn_adj = has_down_q && ({lo_e_q[VAL_W-1], lo_e_q} == vm1);

	assign in_ch.ready = (state_q == FSM_IDLE) && !out_v_q;
	assign out_ch.valid = out_v_q;
	assign out_ch.data = out_q;

	logic in_fire, out_free;
	assign in_fire = in_ch.valid && in_ch.ready;
	assign out_free = !out_v_q || out_ch.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (in_fire) begin
					state_d = in_ch.data.kind ? FSM_LIST : FSM_SRCH;
				end
			end
			FSM_SRCH: state_d = (idx_q < count_q) ? FSM_SRCH_CHK : FSM_DECIDE;
			FSM_SRCH_CHK: state_d = (rd_s < v_q) ? FSM_SRCH : FSM_DECIDE;
			FSM_DECIDE: begin
				if (out_free) begin
					if (cov) begin
						state_d = FSM_IDLE;
					end else if (up_adj && dn_adj) begin
						state_d = FSM_SHDN;
					end else if (up_adj || dn_adj) begin
						state_d = FSM_IDLE;
					end else if (count_q >= CNT_W'(MAX_RANGES)) begin
						state_d = FSM_IDLE;
					end else begin
						state_d = FSM_SHUP;
					end
				end
			end
			FSM_SHDN: state_d = (idx_q < count_q) ? FSM_SHDN_W : FSM_IDLE;
			FSM_SHDN_W: state_d = FSM_SHDN;
			FSM_SHUP: state_d = (idx_q > up_q) ? FSM_SHUP_W : FSM_IDLE;
			FSM_SHUP_W: state_d = FSM_SHUP;
			FSM_LIST: state_d = (count_q == '0) ? FSM_EMIT : FSM_LIST_W;
			FSM_LIST_W: state_d = FSM_EMIT;
			FSM_EMIT: begin
				if (out_free) begin
					state_d = (count_q == '0 || idx_q + 1'b1 >= count_q) ?
						FSM_IDLE : FSM_LIST;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	// RAM port control: the read address is chosen so that the registered data is
	// ready in the following state that needs it.
	always_comb begin
		ram_we = 1'b0;
		ram_addr = idx_q[IDX_W-1:0];
		ram_wdata = ram_rdata;
		case (state_q)
			FSM_DECIDE: begin
				if (out_free && !cov) begin
					if (up_adj && dn_adj) begin
						ram_we = 1'b1;
						ram_addr = IDX_W'(up_q - 1'b1);
						ram_wdata = {lo_s_q, rd_e};
					end else if (up_adj) begin
						ram_we = 1'b1;
						ram_addr = up_q[IDX_W-1:0];
						ram_wdata = {v_q, rd_e};
					end else if (dn_adj) begin
						ram_we = 1'b1;
						ram_addr = IDX_W'(up_q - 1'b1);
						ram_wdata = {lo_s_q, v_q};
					end
				end
			end
			FSM_SHDN: ram_addr = IDX_W'(idx_q + 1'b1);
			FSM_SHDN_W: begin
				ram_we = 1'b1;
				ram_wdata = ram_rdata;
			end
			FSM_SHUP: begin
				ram_addr = (idx_q > up_q) ? IDX_W'(idx_q - 1'b1) : idx_q[IDX_W-1:0];
				ram_we = (idx_q == up_q);
				ram_wdata = {v_q, v_q};
			end
			FSM_SHUP_W: begin
				ram_we = 1'b1;
				ram_wdata = ram_rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			count_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == FSM_DECIDE || state_q == FSM_EMIT) && out_free) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
			if (state_q == FSM_DECIDE && out_free && !cov) begin
				if (up_adj && dn_adj) begin
					count_q <= count_q - 1'b1;
				end else if (!up_adj && !dn_adj && count_q < CNT_W'(MAX_RANGES)) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			FSM_IDLE: begin
				v_q <= in_ch.data.value;
				idx_q <= '0;
				has_down_q <= 1'b0;
			end
			FSM_SRCH: up_q <= idx_q;
			FSM_SRCH_CHK: begin
				if (rd_s < v_q) begin
					has_down_q <= 1'b1;
					lo_s_q <= rd_s;
					lo_e_q <= rd_e;
					idx_q <= idx_q + 1'b1;
				end
			end
			FSM_DECIDE: begin
				out_q.range_low <= '0;
				out_q.range_high <= '0;
				out_q.last <= 1'b1;
				if (cov) begin
					out_q.status <= ST_COVERED;
				end else if (up_adj && dn_adj) begin
					out_q.status <= ST_JOINED;
					idx_q <= up_q;
				end else if (up_adj) begin
					out_q.status <= ST_UPPER_DOWN;
				end else if (dn_adj) begin
					out_q.status <= ST_LOWER_UP;
				end else if (count_q >= CNT_W'(MAX_RANGES)) begin
					out_q.status <= ST_FULL;
				end else begin
					out_q.status <= ST_NEW;
					idx_q <= count_q;
				end
			end
			FSM_SHDN_W: idx_q <= idx_q + 1'b1;
			FSM_SHUP_W: idx_q <= idx_q - 1'b1;
			FSM_EMIT: begin
				if (out_free) begin
					if (count_q == '0) begin
						out_q <= '{ST_EMPTY, '0, '0, 1'b1};
					end else begin
						out_q <= '{ST_LISTED, rd_s, rd_e, idx_q + 1'b1 >= count_q};
						idx_q <= idx_q + 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	ap_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RANGES))
		else $error("range count above capacity");
	ap_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != FSM_IDLE) |-> !in_ch.ready)
		else $error("input accepted while busy");
	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_ch.ready) |=> (out_v_q && $stable(out_q)))
		else $error("stalled result changed");
endmodule
`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench of the disjoint range set merge unit. Add and list items are driven
// in random bursts while the output stalls on its own pattern; a scoreboard
// keeps its own copy of the range table and checks every result in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
	import drsm_pkg::*;

	class range_scoreboard;
		longint starts[$];
		longint ends[$];
		out_item_t pending[$];
		int errors;

		function void queue_expected(out_item_t r);
			pending = {pending, r};
		endfunction

		function void note_item(in_item_t it);
			out_item_t r;
			longint v;
			int up;
			status_t st;
			r = '0;
			r.last = 1'b1;
			if (it.kind) begin
				if (starts.size() == 0) begin
					r.status = ST_EMPTY;
					queue_expected(r);
				end else begin
					for (int i = 0; i < starts.size(); i++) begin
						r.status = ST_LISTED;
						r.range_low = starts[i][31:0];
						r.range_high = ends[i][31:0];
						r.last = (i == starts.size() - 1);
						queue_expected(r);
					end
				end
				return;
			end
			v = longint'($signed(it.value));
			up = 0;
			while (up < starts.size() && starts[up] < v)
				up++;
			if ((up < starts.size() && starts[up] <= v) || (up > 0 && ends[up-1] >= v))
				st = ST_COVERED;
			else if (up < starts.size() && up > 0 && starts[up] == v + 1
					&& ends[up-1] == v - 1) begin
				ends[up-1] = ends[up];
				starts.delete(up);
				ends.delete(up);
				st = ST_JOINED;
			end else if (up < starts.size() && starts[up] == v + 1) begin
				starts[up] = v;
				st = ST_UPPER_DOWN;
			end else if (up > 0 && ends[up-1] == v - 1) begin
				ends[up-1] = v;
				st = ST_LOWER_UP;
			end else if (starts.size() >= MAX_RANGES)
				st = ST_FULL;
			else begin
				starts.insert(up, v);
				ends.insert(up, v);
				st = ST_NEW;
			end
			r.status = st;
			queue_expected(r);
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			if (pending.size() == 0) begin
				$error("unexpected result status=%0d", got.status);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.status !== e.status) begin
				$error("status expected %0d actual %0d", e.status, got.status);
				errors++;
			end
			if (got.range_low !== e.range_low) begin
				$error("range_low expected %0d actual %0d", e.range_low, got.range_low);
				errors++;
			end
			if (got.range_high !== e.range_high) begin
				$error("range_high expected %0d actual %0d", e.range_high,
					got.range_high);
				errors++;
			end
			if (got.last !== e.last) begin
				$error("last expected %0d actual %0d", e.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	drsm_if #(.T(in_item_t)) in_ch ();
	drsm_if #(.T(out_item_t)) out_ch ();
	range_scoreboard sb;
	int idle_cycles;
	int burst_left;
	logic signed [31:0] base;

	disjoint_range_set_merge_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			sb.note_item(in_ch.data);
		if (out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.data);
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// The receiver draws ready anew at every falling edge: mostly high, else random or low.
	initial begin
		int mode;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			mode = $urandom_range(0, 99);
			if (mode < 60)
				out_ch.ready <= 1'b1;
			else if (mode < 95)
				out_ch.ready <= $urandom_range(0, 1);
			else
				out_ch.ready <= 1'b0;
		end
	end

	task automatic send(input logic kind, input logic signed [31:0] value);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= '{kind: kind, value: value};
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic add_random(input logic signed [31:0] centre, input int spread);
		send(1'b0, centre + $signed($urandom_range(0, spread)));
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	initial begin
		int n;
		sb = new();
		idle_cycles = 0;
		burst_left = 0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send(1'b1, 32'sd0);
		send(1'b0, 32'sh7fffffff);
		send(1'b0, 32'sh80000000);
		send(1'b0, 32'sh7ffffffe);
		send(1'b0, 32'sh80000001);
		send(1'b0, 32'sh7fffffff);
		send(1'b0, 32'sd10);
		send(1'b0, 32'sd12);
		send(1'b0, 32'sd11);
		send(1'b0, 32'sd9);
		send(1'b0, 32'sd13);
		send(1'b0, -32'sd1);
		send(1'b0, 32'sh55555555);
		send(1'b0, 32'shaaaaaaaa);
		send(1'b1, 32'shffffffff);
		drain();
		// Fill the table with isolated values, then hit the full case.
		for (int i = 0; i < MAX_RANGES; i++)
			send(1'b0, 32'sd1000 + 3 * i);
		send(1'b0, 32'sd5000);
		send(1'b0, 32'sd999);
		send(1'b1, 32'sd0);
		drain();

		n = 0;
		base = $urandom();
		while (n < 270) begin
			n++;
			case ($urandom_range(0, 19))
				0: send(1'b1, $urandom());
				1: send(1'b0, $urandom());
				2: begin
					base = $urandom();
					add_random(base, 40);
				end
				default: add_random(base, 60 + n % 3 * 40);
			endcase
			if (n == 135)
				drain();
		end
		send(1'b1, 32'sd0);
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire

/* files.f */
src/drsm_pkg.sv
src/drsm_if.sv
src/drsm_ram.sv
src/disjoint_range_set_merge_unit.sv
sim/tb.sv
